@@ rtl/npcm_pkg.sv @@
// shared types, constants and helpers of the nearest palette colour mapper
// no dependencies; imported by npcm_cell and nearest_palette_color_mapper_core
`default_nettype none

package npcm_pkg;

  // field widths
  localparam int unsigned CH_W      = 8;
  localparam int unsigned SQ_W      = 16;
  localparam int unsigned DIST_W    = 18;
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned CFG_IDX_W = 8;

  // request codes of an input transaction
  typedef enum logic {
    REQ_MAP  = 1'b0,
    REQ_LOAD = 1'b1
  } req_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PALETTE_SIZE = 8'd0,
    CFG_KEEP_ALPHA   = 8'd1
  } cfg_reg_t;

  // one transaction travelling down the chain
  typedef struct packed {
    req_t            req_type;
    logic [CH_W-1:0] entry_index;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } npcm_item_t;

  // best match found so far for a pixel
  typedef struct packed {
    logic [DIST_W-1:0] dist_sq;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
  } npcm_best_t;

  // squared absolute difference of two channel values
  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

`default_nettype wire

@@ rtl/npcm_cell.sv @@
// one cell of the search chain: holds one palette entry and updates the best match
// depends on npcm_pkg
`default_nettype none

module npcm_cell
  import npcm_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned IDX_W    = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             active_i,
  input  wire logic             valid_i,
  input  wire npcm_item_t       item_i,
  input  wire npcm_best_t       best_i,
  input  wire logic [IDX_W-1:0] best_idx_i,
  output logic                  valid_o,
  output npcm_item_t            item_o,
  output npcm_best_t            best_o,
  output logic [IDX_W-1:0]      best_idx_o
);

  localparam logic             IDX_REACHABLE = (CELL_IDX < (1 << CH_W));
  localparam logic [CH_W-1:0]  MY_IDX8       = CH_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] MY_IDX        = IDX_W'(CELL_IDX);

  logic              valid_r;
  npcm_item_t        item_r;
  npcm_best_t        best_r;
  npcm_best_t        best_nxt;
  logic [IDX_W-1:0]  best_idx_r;
  logic [IDX_W-1:0]  best_idx_nxt;
  logic [3*CH_W-1:0] entry_r;
  logic              write_en;
  logic              take;
  logic [DIST_W-1:0] entry_dist;

  // load transaction addressed to this cell
  assign write_en = valid_i && (item_i.req_type == REQ_LOAD) && IDX_REACHABLE &&
                    (item_i.entry_index == MY_IDX8);

  // distance of the pixel to the held entry
  assign entry_dist = DIST_W'(sq_diff(item_i.red,   entry_r[3*CH_W-1:2*CH_W])) +
                      DIST_W'(sq_diff(item_i.green, entry_r[2*CH_W-1:CH_W])) +
                      DIST_W'(sq_diff(item_i.blue,  entry_r[CH_W-1:0]));

  // strictly nearer wins, so ties keep the lower index
  assign take = valid_i && (item_i.req_type == REQ_MAP) && active_i &&
                (entry_dist < best_i.dist_sq);

  always_comb begin
    best_nxt     = best_i;
    best_idx_nxt = best_idx_i;
    if (take) begin
      best_nxt.dist_sq = entry_dist;
      best_nxt.red     = entry_r[3*CH_W-1:2*CH_W];
      best_nxt.green   = entry_r[2*CH_W-1:CH_W];
      best_nxt.blue    = entry_r[CH_W-1:0];
      best_idx_nxt     = MY_IDX;
    end
  end

  // transaction valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  // payload handed to the next cell
  always_ff @(posedge clk) begin
    item_r     <= item_i;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
  end

  // palette entry, undefined until loaded
  always_ff @(posedge clk) begin
    if (write_en) begin
      entry_r <= {item_i.red, item_i.green, item_i.blue};
    end
  end

  assign valid_o    = valid_r;
  assign item_o     = item_r;
  assign best_o     = best_r;
  assign best_idx_o = best_idx_r;

endmodule

`default_nettype wire

@@ rtl/nearest_palette_color_mapper_core.sv @@
// nearest palette colour mapper: a chain of PALETTE_DEPTH cells, one palette entry each
// a pixel transaction passes the register of every cell, then the output register, before its result appears
// throughput: one transaction (pixel or load) per cycle while busy is low; each moves one cell per cycle
// loads travel the chain too, so pixels see exactly the loads accepted before them
// reset (synchronous, rst_n low): config to defaults, chain emptied; busy is high in reset
// and until the registered reset-done flag sets after its release; palette contents are undefined until loaded
`default_nettype none

module nearest_palette_color_mapper_core
  import npcm_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input transactions
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_req_type,
  input  wire logic [CH_W-1:0]      in_entry_index,
  input  wire logic [CH_W-1:0]      in_red,
  input  wire logic [CH_W-1:0]      in_green,
  input  wire logic [CH_W-1:0]      in_blue,
  input  wire logic [CH_W-1:0]      in_alpha,
  // results
  output logic                      out_strobe,
  output logic [CH_W-1:0]           out_red,
  output logic [CH_W-1:0]           out_green,
  output logic [CH_W-1:0]           out_blue,
  output logic [CH_W-1:0]           out_alpha,
  output logic [CH_W-1:0]           out_match_index,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_wdata
);

  localparam int unsigned IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);

  logic                    rst_done_r;
  logic [SIZE_W-1:0]       palette_size_r;
  logic                    keep_alpha_r;
  logic [CNT_W-1:0]        n_eff;
  logic [PALETTE_DEPTH-1:0] active;
  logic                    accept;

  logic [PALETTE_DEPTH:0]  vchain;
  npcm_item_t              ichain [0:PALETTE_DEPTH];
  npcm_best_t              bchain [0:PALETTE_DEPTH];
  logic [IDX_W-1:0]        xchain [0:PALETTE_DEPTH];

  logic                    out_strobe_r;
  logic [CH_W-1:0]         out_red_r;
  logic [CH_W-1:0]         out_green_r;
  logic [CH_W-1:0]         out_blue_r;
  logic [CH_W-1:0]         out_alpha_r;
  logic [CH_W-1:0]         out_match_index_r;

  // ready once reset is released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_done_r <= 1'b0;
    end else begin
      rst_done_r <= 1'b1;
    end
  end

  assign busy      = !rst_done_r;
  assign cfg_ready = rst_done_r;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_size_r <= SIZE_W'(1);
      keep_alpha_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PALETTE_SIZE: palette_size_r <= cfg_wdata;
        CFG_KEEP_ALPHA:   keep_alpha_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // entries searched: size clamped to 1..PALETTE_DEPTH
  always_comb begin
    if (palette_size_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(palette_size_r) > 32'(PALETTE_DEPTH)) begin
      n_eff = CNT_W'(PALETTE_DEPTH);
    end else begin
      n_eff = CNT_W'(palette_size_r);
    end
  end

  // head of the chain
  assign vchain[0]                = accept;
  assign ichain[0].req_type       = req_t'(in_req_type);
  assign ichain[0].entry_index    = in_entry_index;
  assign ichain[0].red            = in_red;
  assign ichain[0].green          = in_green;
  assign ichain[0].blue           = in_blue;
  assign ichain[0].alpha          = in_alpha;
  assign bchain[0].dist_sq        = '1;
  assign bchain[0].red            = '0;
  assign bchain[0].green          = '0;
  assign bchain[0].blue           = '0;
  assign xchain[0]                = '0;

  // row of search cells
  for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
    assign active[g] = (n_eff > CNT_W'(g));

    npcm_cell #(
      .CELL_IDX (g),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .active_i   (active[g]),
      .valid_i    (vchain[g]),
      .item_i     (ichain[g]),
      .best_i     (bchain[g]),
      .best_idx_i (xchain[g]),
      .valid_o    (vchain[g+1]),
      .item_o     (ichain[g+1]),
      .best_o     (bchain[g+1]),
      .best_idx_o (xchain[g+1])
    );
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vchain[PALETTE_DEPTH] &&
                      (ichain[PALETTE_DEPTH].req_type == REQ_MAP);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_red_r         <= bchain[PALETTE_DEPTH].red;
    out_green_r       <= bchain[PALETTE_DEPTH].green;
    out_blue_r        <= bchain[PALETTE_DEPTH].blue;
    out_alpha_r       <= keep_alpha_r ? ichain[PALETTE_DEPTH].alpha : '0;
    out_match_index_r <= CH_W'(xchain[PALETTE_DEPTH]);
  end

  assign out_strobe      = out_strobe_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_alpha       = out_alpha_r;
  assign out_match_index = out_match_index_r;

  // every pixel transaction gives a result after the full chain
  a_pixel_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_MAP)) |-> ##(PALETTE_DEPTH + 1) out_strobe)
    else $error("pixel transaction gave no result");

  // a load transaction never gives a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_LOAD)) |-> ##(PALETTE_DEPTH + 1) !out_strobe)
    else $error("load transaction gave a result");

  // the first searched entry always beats the initial distance
  a_first_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (vchain[1] && (ichain[1].req_type == REQ_MAP)) |-> (bchain[1].dist_sq != '1))
    else $error("entry zero not taken");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for nearest_palette_color_mapper_core: palette loads and pixel lookups
// depends on rtl/npcm_pkg.sv and rtl/nearest_palette_color_mapper_core.sv

module tb_top;
  import npcm_pkg::*;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int          PHASE_COUNT   = 8;
  localparam int          PHASE_ITEMS   = 195;
  localparam int          DIR_ROWS      = 16;
  localparam int          DIR_SPLIT     = 3;
  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 8'hFF;

  typedef struct packed {
    req_t            kind;
    logic [CH_W-1:0] idx;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } mapper_txn_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] index;
  } match_t;

  typedef struct packed {
    mapper_txn_t txn;
    bit          typed;
    match_t      want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_req_type;
  logic [CH_W-1:0]      in_entry_index;
  logic [CH_W-1:0]      in_red;
  logic [CH_W-1:0]      in_green;
  logic [CH_W-1:0]      in_blue;
  logic [CH_W-1:0]      in_alpha;
  logic                 out_strobe;
  logic [CH_W-1:0]      out_red;
  logic [CH_W-1:0]      out_green;
  logic [CH_W-1:0]      out_blue;
  logic [CH_W-1:0]      out_alpha;
  logic [CH_W-1:0]      out_match_index;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_wdata;

  // mirror of the block state
  logic [23:0]       palette_mirror [PALETTE_DEPTH];
  bit                entry_loaded   [PALETTE_DEPTH];
  logic [SIZE_W-1:0] size_mirror;
  logic              keep_mirror;

  match_t pending_matches [$];
  int     n_err;
  int     burst_left;

  // directed transactions: typed expectations only where obvious
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{REQ_LOAD, 8'h00, 8'h12, 8'h34, 8'h56, 8'hFF}, 1'b0, '0},
    '{'{REQ_MAP,  8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF}, 1'b1, '{8'h12, 8'h34, 8'h56, 8'h00, 8'h00}},
    '{'{REQ_MAP,  8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h80}, 1'b1, '{8'h12, 8'h34, 8'h56, 8'h00, 8'h00}},
    '{'{REQ_LOAD, 8'h00, 8'h80, 8'h80, 8'h80, 8'h00}, 1'b0, '0},
    '{'{REQ_LOAD, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
    '{'{REQ_LOAD, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'h00}, 1'b0, '0},
    '{'{REQ_LOAD, 8'h03, 8'h00, 8'h00, 8'h00, 8'hFF}, 1'b0, '0},
    '{'{REQ_MAP,  8'h00, 8'h00, 8'h00, 8'h00, 8'h5A}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h5A, 8'h01}},
    '{'{REQ_MAP,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h02}},
    '{'{REQ_MAP,  8'h0F, 8'h40, 8'h40, 8'h40, 8'h00}, 1'b0, '0},
    '{'{REQ_MAP,  8'h00, 8'hFF, 8'h00, 8'hFF, 8'hA5}, 1'b0, '0},
    '{'{REQ_MAP,  8'h00, 8'h00, 8'hFF, 8'h00, 8'hC3}, 1'b0, '0},
    '{'{REQ_LOAD, 8'h03, 8'hFF, 8'h00, 8'hFF, 8'h00}, 1'b0, '0},
    '{'{REQ_MAP,  8'h00, 8'hFF, 8'h00, 8'hFF, 8'h3C}, 1'b1, '{8'hFF, 8'h00, 8'hFF, 8'h3C, 8'h03}},
    '{'{REQ_LOAD, 8'h02, 8'hAA, 8'h55, 8'hAA, 8'h00}, 1'b0, '0},
    '{'{REQ_MAP,  8'h00, 8'hAA, 8'h55, 8'hAA, 8'h01}, 1'b0, '0}
  };

  // settings per random phase; the last two sizes are drawn at run time
  logic [SIZE_W-1:0] phase_size [PHASE_COUNT] = '{
    9'd0, 9'd256, 9'd511, 9'd257, 9'd2, 9'd16, 9'd0, 9'd0
  };
  logic [SIZE_W-1:0] phase_keep [PHASE_COUNT] = '{
    9'h000, 9'h001, 9'h1FE, 9'h1FF, 9'h001, 9'h100, 9'h000, 9'h001
  };

  nearest_palette_color_mapper_core #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_entry_index  (in_entry_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .out_strobe      (out_strobe),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_match_index (out_match_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // number of entries searched, after clamping the register
  function automatic int active_count();
    int n;
    n = int'(size_mirror);
    if (n == 0) n = 1;
    if (n > int'(PALETTE_DEPTH)) n = PALETTE_DEPTH;
    return n;
  endfunction

  // exhaustive search, lowest index wins on equal distance
  function automatic match_t nearest_entry(input mapper_txn_t t);
    match_t m;
    int     best_d;
    int     best_i;
    int     d;
    int     dr;
    int     dg;
    int     db;
    best_d = 32'h7FFF_FFFF;
    best_i = 0;
    for (int i = 0; i < active_count(); i++) begin
      dr = int'(t.red)   - int'(palette_mirror[i][23:16]);
      dg = int'(t.green) - int'(palette_mirror[i][15:8]);
      db = int'(t.blue)  - int'(palette_mirror[i][7:0]);
      d  = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d = d;
        best_i = i;
      end
    end
    m.red   = palette_mirror[best_i][23:16];
    m.green = palette_mirror[best_i][15:8];
    m.blue  = palette_mirror[best_i][7:0];
    m.alpha = keep_mirror ? t.alpha : 8'h00;
    m.index = best_i[CH_W-1:0];
    return m;
  endfunction

  // idle cycles before a transaction: mostly short, a few long, some bursts with none
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 80);
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CH_W-1:0] extreme_chan();
    return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
  endfunction

  // random transaction that only reads loaded entries
  function automatic mapper_txn_t random_txn(input int n);
    mapper_txn_t t;
    int          mode;
    int          pick;
    logic [23:0] e;
    t.idx   = CH_W'($urandom);
    t.red   = CH_W'($urandom);
    t.green = CH_W'($urandom);
    t.blue  = CH_W'($urandom);
    t.alpha = CH_W'($urandom);
    pick    = $urandom_range(0, n - 1);
    e       = palette_mirror[pick];
    mode    = $urandom_range(0, 9);
    if ($urandom_range(0, 99) < 30) begin
      // palette load, often inside the searched range, sometimes a duplicate colour
      t.kind = REQ_LOAD;
      if ($urandom_range(0, 1) != 0) t.idx = CH_W'($urandom_range(0, n - 1));
      if (mode < 3) begin
        e = palette_mirror[$urandom_range(0, n - 1)];
        {t.red, t.green, t.blue} = e;
      end else if (mode < 5) begin
        t.red   = extreme_chan();
        t.green = extreme_chan();
        t.blue  = extreme_chan();
      end
    end else begin
      // pixel: exact hit, near miss, extremes or anything
      t.kind = REQ_MAP;
      if (mode < 3) begin
        {t.red, t.green, t.blue} = e;
      end else if (mode < 5) begin
        t.red   = e[23:16] + CH_W'($urandom_range(0, 6)) - 8'd3;
        t.green = e[15:8]  + CH_W'($urandom_range(0, 6)) - 8'd3;
        t.blue  = e[7:0]   + CH_W'($urandom_range(0, 6)) - 8'd3;
      end else if (mode < 6) begin
        t.red   = extreme_chan();
        t.green = extreme_chan();
        t.blue  = extreme_chan();
      end
      if ($urandom_range(0, 9) == 0) t.alpha = extreme_chan();
    end
    return t;
  endfunction

  // drop start at the next falling edge
  task automatic release_start();
    @(negedge clk);
    start = 1'b0;
  endtask

  // one input transaction; start stays high afterwards until the next call or release
  task automatic send_txn(input mapper_txn_t t, input bit typed, input match_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      release_start();
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start          = 1'b1;
    in_req_type    = t.kind;
    in_entry_index = t.idx;
    in_red         = t.red;
    in_green       = t.green;
    in_blue        = t.blue;
    in_alpha       = t.alpha;
    do @(posedge clk); while (busy !== 1'b0);
    if (t.kind == REQ_LOAD) begin
      palette_mirror[t.idx] = {t.red, t.green, t.blue};
      entry_loaded[t.idx]   = 1'b1;
    end else begin
      pending_matches.push_back(typed ? want : nearest_entry(t));
    end
  endtask

  // wait for every pending result
  task automatic drain_results();
    release_start();
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  // drained, then long enough for loads still moving down the chain
  task automatic wait_idle();
    drain_results();
    repeat (PALETTE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_PALETTE_SIZE) size_mirror = data;
    else if (idx == CFG_KEEP_ALPHA) keep_mirror = data[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [CH_W-1:0] exp_v,
                             input logic [CH_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      n_err++;
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_mon
    match_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_matches.size() == 0) begin
        $error("result transaction with nothing expected");
        n_err++;
      end else begin
        want = pending_matches.pop_front();
        check_field("out_red", want.red, out_red);
        check_field("out_green", want.green, out_green);
        check_field("out_blue", want.blue, out_blue);
        check_field("out_alpha", want.alpha, out_alpha);
        check_field("out_match_index", want.index, out_match_index);
      end
    end
  end

  // stimulus
  initial begin : stim
    mapper_txn_t t;
    int          n;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_req_type    = REQ_MAP;
    in_entry_index = '0;
    in_red         = '0;
    in_green       = '0;
    in_blue        = '0;
    in_alpha       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_PALETTE_SIZE;
    cfg_wdata      = '0;
    n_err          = 0;
    burst_left     = 0;
    size_mirror    = 9'd1;
    keep_mirror    = 1'b0;
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      palette_mirror[i] = '0;
      entry_loaded[i]   = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, reset settings first, then a four-entry palette with alpha kept
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_SPLIT) begin
        wait_idle();
        cfg_write(CFG_PALETTE_SIZE, 9'd4);
        cfg_write(CFG_KEEP_ALPHA, 9'd1);
      end
      send_txn(dir_tab[i].txn, dir_tab[i].typed, dir_tab[i].want);
    end

    // random phases over several settings, extremes among them
    phase_size[6] = SIZE_W'($urandom_range(3, 511));
    phase_size[7] = SIZE_W'($urandom_range(3, 48));
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      cfg_write(CFG_PALETTE_SIZE, phase_size[p]);
      cfg_write(CFG_KEEP_ALPHA, phase_keep[p]);
      if (p == 2) begin
        // writes to indexes with no register must change nothing
        cfg_write(CFG_UNMAPPED_HI, 9'h1FF);
        cfg_write(CFG_UNMAPPED_LO, 9'h000);
      end
      n = active_count();
      // load any entry in the searched range that was never written
      for (int i = 0; i < n; i++) begin
        if (!entry_loaded[i]) begin
          t       = random_txn(1);
          t.kind  = REQ_LOAD;
          t.idx   = CH_W'(i);
          send_txn(t, 1'b0, '0);
        end
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain_results();
        send_txn(random_txn(n), 1'b0, '0);
      end
    end

    drain_results();
    repeat (PALETTE_DEPTH + 16) @(posedge clk);
    if (n_err == 0 && pending_matches.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
